// ----- hw/rtl/vsrd_pkg.sv -----
// ----------------------------------------------------------------------------
// Vector shape record decoder package
// Shared types, codes and helper functions of the shape record decoder.
// ----------------------------------------------------------------------------
package vsrd_pkg;

	localparam int COORD_BITS = 32;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int STYLE_W    = 15;
	localparam int ACC_W      = 32;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_HEADER,
		PH_REC,
		PH_EDGE,
		PH_SNBITS,
		PH_CNBITS,
		PH_GENERAL,
		PH_VERT,
		PH_LDX,
		PH_LDY,
		PH_HV,
		PH_CCX,
		PH_CCY,
		PH_CAX,
		PH_CAY,
		PH_FLAGS,
		PH_MNBITS,
		PH_MX,
		PH_MY,
		PH_FILL0,
		PH_FILL1,
		PH_LSTYLE,
		PH_STNEXT
	} phase_t;

	typedef enum logic [2:0] {
		KIND_LINE  = 3'd0,
		KIND_CURVE = 3'd1,
		KIND_MOVE  = 3'd2,
		KIND_END   = 3'd3,
		KIND_ERROR = 3'd4
	} kind_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	localparam logic REG_SHAPE_VERSION = 1'b0;

	localparam logic [2:0] VERSION_RESET = 3'd1;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		kind_t               kind;
		logic signed [31:0]  pos_x;
		logic signed [31:0]  pos_y;
		logic signed [31:0]  ctrl_x;
		logic signed [31:0]  ctrl_y;
		logic [STYLE_W-1:0]  fill_left;
		logic [STYLE_W-1:0]  fill_right;
		logic [STYLE_W-1:0]  stroke_index;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} emit_t;

	typedef struct packed {
		phase_t     phase;
		logic [4:0] n;
		logic       err;
	} style_step_t;

	// Sign-extends a coordinate to 64 bits and keeps the low 32 bits.
	function automatic logic signed [31:0] coord_out(input coord_t c);
		logic signed [63:0] w;
		w = 64'(signed'(c));
		return w[31:0];
	endfunction

	// Adds an n-bit two's complement field to a base, wrapping at the coordinate width.
	function automatic coord_t sext_add(input coord_t base, input logic [ACC_W-1:0] a,
			input logic [4:0] n);
		logic [63:0] v;
		logic [63:0] m;
		v = {32'd0, a};
		m = (64'd1 << n) - 64'd1;
		if (n == 5'd0) begin
			v = 64'd0;
		end else if (a[5'(n - 5'd1)]) begin
			v = v | ~m;
		end
		return base + v[COORD_BITS-1:0];
	endfunction

endpackage

// ----- hw/rtl/vector_shape_record_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Vector shape record decoder core
// Decodes a byte stream of vector shape records into path elements.
// ----------------------------------------------------------------------------
// A request carries a command and a byte. A start command clears the parser;
// the first data byte after it sets the fill and line index widths. Every
// later data byte is parsed one bit per cycle, while no response is held
// back at the output, by a field sequencer that shares a single coordinate
// adder. Each completed field takes a step of its own, as does the style
// step after a move record, and a closing step follows; req_ready stays low
// until then, or until the shape ends inside the byte, so the block takes
// no new data byte before it is through with the last one.
// Each line, curve or move leaves one response, which shows on rsp_valid the
// cycle after its last field completes; an end record or an
// unsupported new-styles record leaves a response marked last, and further
// data bytes are dropped until the next start command.
// Responses sit in a single output register. When the receiver stalls with
// that register full, the sequencer holds on the field that produces the
// next response. Reset returns the parser to waiting for a start command and
// sets shape_version to 1. The user writes shape_version over the APB port at
// byte address 0 only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module vector_shape_record_decoder_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  vsrd_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output vsrd_pkg::rsp_t                   rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [vsrd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [vsrd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [vsrd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import vsrd_pkg::*;

	logic [2:0] shape_version_q;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	logic       emit_ready;
	emit_t      emit;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SHAPE_VERSION) begin
			prdata = {{(APB_DATA_W-3){1'b0}}, shape_version_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_version_q <= VERSION_RESET;
		end else if (cfg_wr && paddr[2] == REG_SHAPE_VERSION) begin
			shape_version_q <= pwdata[2:0];
		end
	end

	vsrd_bit_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.shape_version (shape_version_q),
		.emit_ready    (emit_ready),
		.emit          (emit)
	);

	assign emit_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit.valid && emit_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit_ready) begin
			rsp_q <= emit.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid && emit_ready |=> rsp_valid_q)
		else $error("response from the engine was not registered");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.last == (rsp_q.kind == KIND_END || rsp_q.kind == KIND_ERROR))
		else $error("last flag does not match response kind");

	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.kind != KIND_CURVE |-> rsp_q.ctrl_x == 0 && rsp_q.ctrl_y == 0)
		else $error("control point set on a non-curve response");

	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.last |-> rsp_q.pos_x == 0 && rsp_q.pos_y == 0 &&
			rsp_q.fill_left == 0 && rsp_q.fill_right == 0 && rsp_q.stroke_index == 0)
		else $error("closing response carries nonzero fields");

endmodule

// ----- hw/rtl/vsrd_bit_engine.sv -----
// ----------------------------------------------------------------------------
// Shape record bit engine
// Bit-serial field parser with one shared coordinate adder under a sequencer.
// ----------------------------------------------------------------------------
module vsrd_bit_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  vsrd_pkg::req_t       req,
	input  logic [2:0]           shape_version,
	input  logic                 emit_ready,
	output vsrd_pkg::emit_t      emit
);
	import vsrd_pkg::*;

	logic                busy_q, busy_d;
	logic [7:0]          byte_q, byte_d;
	logic [3:0]          bit_cnt_q, bit_cnt_d;
	phase_t              phase_q, phase_d;
	logic [ACC_W-1:0]    accum_q, accum_d;
	logic [4:0]          left_q, left_d;
	logic [4:0]          dw_q, dw_d;
	logic [4:0]          flags_q, flags_d;
	logic [3:0]          fw_q, fw_d;
	logic [3:0]          sw_q, sw_d;
	coord_t              x_q, x_d;
	coord_t              y_q, y_d;
	coord_t              cx_q, cx_d;
	coord_t              cy_q, cy_d;
	logic [STYLE_W-1:0]  fl_q, fl_d;
	logic [STYLE_W-1:0]  fr_q, fr_d;
	logic [STYLE_W-1:0]  st_q, st_d;

	logic                pending;
	logic                stall;
	logic                emit_req;
	kind_t               emit_kind;
	coord_t              add_base;
	coord_t              sum;
	coord_t              px;
	coord_t              py;
	logic [2:0]          sn_stage;
	logic [4:0]          sn_flags;
	style_step_t         sn;

	function automatic style_step_t style_next(input logic [2:0] stage,
			input logic [4:0] flags, input logic [2:0] ver,
			input logic [3:0] fw, input logic [3:0] sw);
		style_step_t s;
		s.phase = PH_REC;
		s.n     = 5'd1;
		s.err   = 1'b0;
		if (stage < 3'd2 && flags[1]) begin
			s.phase = PH_FILL0;
			s.n     = {1'b0, fw};
		end else if (stage < 3'd3 && flags[2]) begin
			s.phase = PH_FILL1;
			s.n     = {1'b0, fw};
		end else if (stage < 3'd4 && flags[3]) begin
			s.phase = PH_LSTYLE;
			s.n     = {1'b0, sw};
		end else if (flags[4] && (ver == 3'd2 || ver == 3'd3)) begin
			s.phase = PH_IDLE;
			s.n     = 5'd0;
			s.err   = 1'b1;
		end
		return s;
	endfunction

	assign pending = busy_q && left_q == 5'd0 && phase_q != PH_IDLE && phase_q != PH_HEADER;

	always_comb begin : decode
		sn_stage  = 3'd1;
		sn_flags  = flags_q;
		emit_req  = 1'b0;
		emit_kind = KIND_LINE;
		add_base  = x_q;
		px        = x_q;
		py        = y_q;
		case (phase_q)
			PH_FLAGS: begin
				sn_flags = accum_q[4:0];
			end
			PH_FILL0: begin
				sn_stage = 3'd2;
			end
			PH_FILL1: begin
				sn_stage = 3'd3;
			end
			PH_LSTYLE: begin
				sn_stage = 3'd4;
			end
			default: begin
				sn_stage = 3'd1;
			end
		endcase
		sn = style_next(sn_stage, sn_flags, shape_version, fw_q, sw_q);
		case (phase_q)
			PH_MX, PH_MY: begin
				add_base = '0;
			end
			PH_LDY, PH_CCY, PH_CAY: begin
				add_base = y_q;
			end
			PH_HV: begin
				add_base = flags_q[0] ? y_q : x_q;
			end
			default: begin
				add_base = x_q;
			end
		endcase
		sum = sext_add(add_base, accum_q, dw_q);
		case (phase_q)
			PH_LDY, PH_CAY, PH_MY: begin
				py = sum;
			end
			PH_HV: begin
				if (flags_q[0]) begin
					py = sum;
				end else begin
					px = sum;
				end
			end
			default: begin
				px = x_q;
			end
		endcase
		if (pending) begin
			case (phase_q)
				PH_LDY, PH_HV: begin
					emit_req  = 1'b1;
					emit_kind = KIND_LINE;
				end
				PH_CAY: begin
					emit_req  = 1'b1;
					emit_kind = KIND_CURVE;
				end
				PH_MY: begin
					emit_req  = 1'b1;
					emit_kind = KIND_MOVE;
				end
				PH_FLAGS: begin
					if (accum_q[4:0] == 5'd0) begin
						emit_req  = 1'b1;
						emit_kind = KIND_END;
					end else if (!accum_q[0] && sn.err) begin
						emit_req  = 1'b1;
						emit_kind = KIND_ERROR;
					end
				end
				PH_FILL0, PH_FILL1, PH_LSTYLE, PH_STNEXT: begin
					if (sn.err) begin
						emit_req  = 1'b1;
						emit_kind = KIND_ERROR;
					end
				end
				default: begin
					emit_req = 1'b0;
				end
			endcase
		end
	end

	assign stall = emit_req && !emit_ready;

	always_comb begin : next_state
		busy_d    = busy_q;
		byte_d    = byte_q;
		bit_cnt_d = bit_cnt_q;
		phase_d   = phase_q;
		accum_d   = accum_q;
		left_d    = left_q;
		dw_d      = dw_q;
		flags_d   = flags_q;
		fw_d      = fw_q;
		sw_d      = sw_q;
		x_d       = x_q;
		y_d       = y_q;
		cx_d      = cx_q;
		cy_d      = cy_q;
		fl_d      = fl_q;
		fr_d      = fr_q;
		st_d      = st_q;
		if (!busy_q) begin
			if (req_valid) begin
				if (req.cmd == CMD_START) begin
					phase_d = PH_HEADER;
					accum_d = '0;
					left_d  = '0;
					dw_d    = '0;
					flags_d = '0;
					fw_d    = '0;
					sw_d    = '0;
					x_d     = '0;
					y_d     = '0;
					cx_d    = '0;
					cy_d    = '0;
					fl_d    = '0;
					fr_d    = '0;
					st_d    = '0;
				end else if (phase_q == PH_HEADER) begin
					fw_d    = req.data_byte[7:4];
					sw_d    = req.data_byte[3:0];
					phase_d = PH_REC;
					left_d  = 5'd1;
					accum_d = '0;
				end else if (phase_q != PH_IDLE) begin
					busy_d    = 1'b1;
					byte_d    = req.data_byte;
					bit_cnt_d = 4'd8;
				end
			end
		end else if (pending) begin
			if (!stall) begin
				accum_d = '0;
				case (phase_q)
					PH_REC: begin
						phase_d = (accum_q != '0) ? PH_EDGE : PH_FLAGS;
						left_d  = (accum_q != '0) ? 5'd1 : 5'd5;
					end
					PH_EDGE: begin
						phase_d = (accum_q != '0) ? PH_SNBITS : PH_CNBITS;
						left_d  = 5'd4;
					end
					PH_SNBITS: begin
						dw_d    = {1'b0, accum_q[3:0]} + 5'd2;
						phase_d = PH_GENERAL;
						left_d  = 5'd1;
					end
					PH_CNBITS: begin
						dw_d    = {1'b0, accum_q[3:0]} + 5'd2;
						phase_d = PH_CCX;
						left_d  = {1'b0, accum_q[3:0]} + 5'd2;
					end
					PH_GENERAL: begin
						phase_d = (accum_q != '0) ? PH_LDX : PH_VERT;
						left_d  = (accum_q != '0) ? dw_q : 5'd1;
					end
					PH_VERT: begin
						flags_d = {4'd0, accum_q[0]};
						phase_d = PH_HV;
						left_d  = dw_q;
					end
					PH_LDX: begin
						x_d     = sum;
						phase_d = PH_LDY;
						left_d  = dw_q;
					end
					PH_LDY: begin
						y_d     = sum;
						phase_d = PH_REC;
						left_d  = 5'd1;
					end
					PH_HV: begin
						x_d     = px;
						y_d     = py;
						phase_d = PH_REC;
						left_d  = 5'd1;
					end
					PH_CCX: begin
						x_d     = sum;
						phase_d = PH_CCY;
						left_d  = dw_q;
					end
					PH_CCY: begin
						y_d     = sum;
						cx_d    = x_q;
						cy_d    = sum;
						phase_d = PH_CAX;
						left_d  = dw_q;
					end
					PH_CAX: begin
						x_d     = sum;
						phase_d = PH_CAY;
						left_d  = dw_q;
					end
					PH_CAY: begin
						y_d     = sum;
						phase_d = PH_REC;
						left_d  = 5'd1;
					end
					PH_FLAGS: begin
						flags_d = accum_q[4:0];
						if (accum_q[4:0] == 5'd0) begin
							phase_d = PH_IDLE;
							accum_d = accum_q;
						end else if (accum_q[0]) begin
							phase_d = PH_MNBITS;
							left_d  = 5'd5;
						end else if (sn.err) begin
							phase_d = PH_IDLE;
							accum_d = accum_q;
						end else begin
							phase_d = sn.phase;
							left_d  = sn.n;
						end
					end
					PH_MNBITS: begin
						dw_d    = accum_q[4:0];
						phase_d = PH_MX;
						left_d  = accum_q[4:0];
					end
					PH_MX: begin
						x_d     = sum;
						phase_d = PH_MY;
						left_d  = dw_q;
					end
					PH_MY: begin
						y_d     = sum;
						phase_d = PH_STNEXT;
						left_d  = 5'd0;
					end
					PH_FILL0, PH_FILL1, PH_LSTYLE, PH_STNEXT: begin
						if (phase_q == PH_FILL0) begin
							fl_d = accum_q[STYLE_W-1:0];
						end
						if (phase_q == PH_FILL1) begin
							fr_d = accum_q[STYLE_W-1:0];
						end
						if (phase_q == PH_LSTYLE) begin
							st_d = accum_q[STYLE_W-1:0];
						end
						if (sn.err) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = sn.phase;
							left_d  = sn.n;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end else if (phase_q == PH_IDLE || bit_cnt_q == 4'd0) begin
			busy_d = 1'b0;
		end else begin
			accum_d   = {accum_q[ACC_W-2:0], byte_q[7]};
			byte_d    = {byte_q[6:0], 1'b0};
			left_d    = left_q - 5'd1;
			bit_cnt_d = bit_cnt_q - 4'd1;
		end
	end

	always_comb begin : outputs
		req_ready = !busy_q;
		emit.valid = emit_req;
		emit.rsp   = '0;
		emit.rsp.kind = emit_kind;
		if (emit_kind == KIND_END || emit_kind == KIND_ERROR) begin
			emit.rsp.last = 1'b1;
		end else begin
			emit.rsp.pos_x        = coord_out(px);
			emit.rsp.pos_y        = coord_out(py);
			emit.rsp.fill_left    = fl_q;
			emit.rsp.fill_right   = fr_q;
			emit.rsp.stroke_index = st_q;
			if (emit_kind == KIND_CURVE) begin
				emit.rsp.ctrl_x = coord_out(cx_q);
				emit.rsp.ctrl_y = coord_out(cy_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			byte_q    <= '0;
			bit_cnt_q <= '0;
			phase_q   <= PH_IDLE;
			accum_q   <= '0;
			left_q    <= '0;
			dw_q      <= '0;
			flags_q   <= '0;
			fw_q      <= '0;
			sw_q      <= '0;
			x_q       <= '0;
			y_q       <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			fl_q      <= '0;
			fr_q      <= '0;
			st_q      <= '0;
		end else begin
			busy_q    <= busy_d;
			byte_q    <= byte_d;
			bit_cnt_q <= bit_cnt_d;
			phase_q   <= phase_d;
			accum_q   <= accum_d;
			left_q    <= left_d;
			dw_q      <= dw_d;
			flags_q   <= flags_d;
			fw_q      <= fw_d;
			sw_q      <= sw_d;
			x_q       <= x_d;
			y_q       <= y_d;
			cx_q      <= cx_d;
			cy_q      <= cy_d;
			fl_q      <= fl_d;
			fr_q      <= fr_d;
			st_q      <= st_d;
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector shape record decoder core testbench
// Streams start commands and shape record bytes into the decoder under every
// shape_version setting, predicts each path element with a bit-serial field
// parser of its own, and checks every response field against that prediction
// while both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb;
	import vsrd_pkg::*;

	typedef enum int {
		P_IDLE, P_WIDTHS, P_REC, P_EDGE, P_STRAIGHT_NB, P_CURVE_NB, P_GENERAL, P_VERT,
		P_LINE_DX, P_LINE_DY, P_AXIS_D, P_CTRL_DX, P_CTRL_DY, P_ANCHOR_DX, P_ANCHOR_DY,
		P_FLAGS, P_MOVE_NB, P_MOVE_X, P_MOVE_Y, P_FILL0, P_FILL1, P_STROKE
	} field_t;

	class path_element_scoreboard;
		rsp_t               expected_elements[$];
		int                 errors;
		int                 checked;
		logic [2:0]         version;
		field_t             field;
		logic [31:0]        accum;
		logic [4:0]         bits_left;
		logic [4:0]         delta_w;
		logic [4:0]         flags;
		logic [3:0]         fill_w;
		logic [3:0]         stroke_w;
		coord_t             x, y, ctrl_x, ctrl_y;
		logic [STYLE_W-1:0] fill_l, fill_r, stroke;
		int                 produced;

		function new();
			errors = 0;
			checked = 0;
			version = VERSION_RESET;
			clear();
		endfunction

		function void clear();
			field = P_IDLE;
			accum = '0;
			bits_left = '0;
			delta_w = '0;
			flags = '0;
			fill_w = '0;
			stroke_w = '0;
			x = '0;
			y = '0;
			ctrl_x = '0;
			ctrl_y = '0;
			fill_l = '0;
			fill_r = '0;
			stroke = '0;
		endfunction

		function void open(field_t f, logic [4:0] n);
			field = f;
			bits_left = n;
			accum = '0;
		endfunction

		function coord_t widen(logic [31:0] a, logic [4:0] n);
			logic [63:0] m;
			logic [63:0] v;
			m = (64'd1 << n) - 64'd1;
			v = {32'd0, a} & m;
			if (n == 5'd0) begin
				v = '0;
			end else if (a[n - 5'd1]) begin
				v = v | ~m;
			end
			return v[COORD_BITS-1:0];
		endfunction

		function void emit_element(kind_t k, bit full, coord_t cx, coord_t cy);
			rsp_t e;
			if (produced >= 2) return;
			e.kind = k;
			e.pos_x = full ? x : '0;
			e.pos_y = full ? y : '0;
			e.ctrl_x = cx;
			e.ctrl_y = cy;
			e.fill_left = full ? fill_l : '0;
			e.fill_right = full ? fill_r : '0;
			e.stroke_index = full ? stroke : '0;
			e.last = !full;
			expected_elements = {expected_elements, e};
			produced++;
		endfunction

		// Stage 1 follows the flags or the move, 2 the first fill, 3 the second fill, 4 the line style.
		function void style_next(int stage);
			if (stage < 2 && flags[1]) begin
				open(P_FILL0, 5'(fill_w));
			end else if (stage < 3 && flags[2]) begin
				open(P_FILL1, 5'(fill_w));
			end else if (stage < 4 && flags[3]) begin
				open(P_STROKE, 5'(stroke_w));
			end else if (flags[4] && (version == 3'd2 || version == 3'd3)) begin
				emit_element(KIND_ERROR, 1'b0, '0, '0);
				field = P_IDLE;
			end else begin
				open(P_REC, 5'd1);
			end
		endfunction

		function void close_field();
			logic [31:0] a;
			a = accum;
			case (field)
				P_REC: begin
					if (a != 0) open(P_EDGE, 5'd1);
					else open(P_FLAGS, 5'd5);
				end
				P_EDGE: begin
					if (a != 0) open(P_STRAIGHT_NB, 5'd4);
					else open(P_CURVE_NB, 5'd4);
				end
				P_STRAIGHT_NB: begin
					delta_w = 5'(a[3:0]) + 5'd2;
					open(P_GENERAL, 5'd1);
				end
				P_CURVE_NB: begin
					delta_w = 5'(a[3:0]) + 5'd2;
					open(P_CTRL_DX, delta_w);
				end
				P_GENERAL: begin
					if (a != 0) open(P_LINE_DX, delta_w);
					else open(P_VERT, 5'd1);
				end
				P_VERT: begin
					flags = {4'd0, a[0]};
					open(P_AXIS_D, delta_w);
				end
				P_LINE_DX: begin
					x = x + widen(a, delta_w);
					open(P_LINE_DY, delta_w);
				end
				P_LINE_DY: begin
					y = y + widen(a, delta_w);
					emit_element(KIND_LINE, 1'b1, '0, '0);
					open(P_REC, 5'd1);
				end
				P_AXIS_D: begin
					if (flags[0]) y = y + widen(a, delta_w);
					else x = x + widen(a, delta_w);
					emit_element(KIND_LINE, 1'b1, '0, '0);
					open(P_REC, 5'd1);
				end
				P_CTRL_DX: begin
					x = x + widen(a, delta_w);
					open(P_CTRL_DY, delta_w);
				end
				P_CTRL_DY: begin
					y = y + widen(a, delta_w);
					ctrl_x = x;
					ctrl_y = y;
					open(P_ANCHOR_DX, delta_w);
				end
				P_ANCHOR_DX: begin
					x = x + widen(a, delta_w);
					open(P_ANCHOR_DY, delta_w);
				end
				P_ANCHOR_DY: begin
					y = y + widen(a, delta_w);
					emit_element(KIND_CURVE, 1'b1, ctrl_x, ctrl_y);
					open(P_REC, 5'd1);
				end
				P_FLAGS: begin
					flags = a[4:0];
					if (flags == 5'd0) begin
						emit_element(KIND_END, 1'b0, '0, '0);
						field = P_IDLE;
					end else if (flags[0]) begin
						open(P_MOVE_NB, 5'd5);
					end else begin
						style_next(1);
					end
				end
				P_MOVE_NB: begin
					delta_w = a[4:0];
					open(P_MOVE_X, delta_w);
				end
				P_MOVE_X: begin
					x = widen(a, delta_w);
					open(P_MOVE_Y, delta_w);
				end
				P_MOVE_Y: begin
					y = widen(a, delta_w);
					emit_element(KIND_MOVE, 1'b1, '0, '0);
					style_next(1);
				end
				P_FILL0: begin
					fill_l = a[STYLE_W-1:0];
					style_next(2);
				end
				P_FILL1: begin
					fill_r = a[STYLE_W-1:0];
					style_next(3);
				end
				P_STROKE: begin
					stroke = a[STYLE_W-1:0];
					style_next(4);
				end
				default: field = P_IDLE;
			endcase
		endfunction

		function void settle();
			while (field != P_IDLE && field != P_WIDTHS && bits_left == 5'd0) close_field();
		endfunction

		function void note_request(req_t r);
			produced = 0;
			if (r.cmd == CMD_START) begin
				clear();
				field = P_WIDTHS;
				return;
			end
			if (field == P_IDLE) return;
			if (field == P_WIDTHS) begin
				fill_w = r.data_byte[7:4];
				stroke_w = r.data_byte[3:0];
				open(P_REC, 5'd1);
				return;
			end
			for (int i = 7; i >= 0; i--) begin
				settle();
				if (field == P_IDLE) break;
				accum = {accum[30:0], r.data_byte[i]};
				bits_left = bits_left - 5'd1;
				settle();
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 50) $display("%0t: mismatch: %s", $realtime, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("element %0d %s is %0h, expected %0h",
					checked, name, got, want));
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (expected_elements.size() == 0) begin
				report_mismatch($sformatf("unexpected element of kind %0d", got.kind));
				return;
			end
			want = expected_elements.pop_front();
			checked++;
			compare_field("kind", 32'(got.kind), 32'(want.kind));
			compare_field("pos_x", got.pos_x, want.pos_x);
			compare_field("pos_y", got.pos_y, want.pos_y);
			compare_field("ctrl_x", got.ctrl_x, want.ctrl_x);
			compare_field("ctrl_y", got.ctrl_y, want.ctrl_y);
			compare_field("fill_left", 32'(got.fill_left), 32'(want.fill_left));
			compare_field("fill_right", 32'(got.fill_right), 32'(want.fill_right));
			compare_field("stroke_index", 32'(got.stroke_index), 32'(want.stroke_index));
			compare_field("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	path_element_scoreboard sb;
	int                     src_idle;
	int                     sink_idle;
	bit                     stream_bits[$];
	int                     shapes_sent;
	int                     requests_counted;
	int                     settings_used;

	vector_shape_record_decoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= sink_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) sb.note_request(req);
			if (rsp_valid && rsp_ready) sb.check_response(rsp);
		end
	end

	task automatic send_request(cmd_t c, logic [7:0] b);
		if ($urandom_range(0, 99) < src_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
		end
		req <= '{cmd: c, data_byte: b};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		requests_counted++;
	endtask

	task automatic write_version(logic [2:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_SHAPE_VERSION, 2'b00};
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.version = v;
		settings_used++;
		@(posedge clk);
		if (pready !== 1'b1 || prdata !== 32'(v))
			sb.report_mismatch($sformatf("shape_version reads back as %0h", prdata));
	endtask

	// The last request may still be parsed after its final element, so a pause follows.
	task automatic drain();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_elements.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (32) @(posedge clk);
	endtask

	function automatic void put_bits(logic [31:0] v, int w);
		for (int i = w - 1; i >= 0; i--) stream_bits = {stream_bits, v[i]};
	endfunction

	function automatic void put_line(int nb, logic [31:0] dx, logic [31:0] dy);
		put_bits(32'd3, 2);
		put_bits(nb, 4);
		put_bits(32'd1, 1);
		put_bits(dx, nb + 2);
		put_bits(dy, nb + 2);
	endfunction

	function automatic void put_axis(int nb, bit vert, logic [31:0] d);
		put_bits(32'd3, 2);
		put_bits(nb, 4);
		put_bits(32'(vert), 2);
		put_bits(d, nb + 2);
	endfunction

	function automatic void put_curve(int nb, logic [31:0] cx, logic [31:0] cy,
			logic [31:0] ax, logic [31:0] ay);
		put_bits(32'd2, 2);
		put_bits(nb, 4);
		put_bits(cx, nb + 2);
		put_bits(cy, nb + 2);
		put_bits(ax, nb + 2);
		put_bits(ay, nb + 2);
	endfunction

	function automatic void put_style(logic [4:0] fl, int mw, logic [31:0] mx,
			logic [31:0] my, logic [31:0] f0, logic [31:0] f1, logic [31:0] ls,
			int fw, int sw);
		put_bits(32'(fl), 6);
		if (fl[0]) begin
			put_bits(mw, 5);
			put_bits(mx, mw);
			put_bits(my, mw);
		end
		if (fl[1]) put_bits(f0, fw);
		if (fl[2]) put_bits(f1, fw);
		if (fl[3]) put_bits(ls, sw);
	endfunction

	function automatic int pick_width();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
	endfunction

	task automatic send_shape(logic [7:0] start_byte, logic [7:0] widths);
		logic [7:0] b;
		send_request(CMD_START, start_byte);
		send_request(CMD_DATA, widths);
		while (stream_bits.size() % 8 != 0) put_bits(32'($urandom_range(0, 1)), 1);
		while (stream_bits.size() != 0) begin
			for (int i = 7; i >= 0; i--) b[i] = stream_bits.pop_front();
			send_request(CMD_DATA, b);
		end
		shapes_sent++;
	endtask

	task automatic random_shape();
		int         fw;
		int         sw;
		int         sel;
		int         nb;
		logic [4:0] fl;
		fw = pick_width();
		sw = pick_width();
		repeat ($urandom_range(1, 8)) begin
			sel = $urandom_range(0, 9);
			nb = $urandom_range(0, 15);
			if (sel < 3) begin
				put_line(nb, $urandom, $urandom);
			end else if (sel < 5) begin
				put_axis(nb, 1'($urandom), $urandom);
			end else if (sel < 7) begin
				put_curve(nb, $urandom, $urandom, $urandom, $urandom);
			end else begin
				fl = 5'($urandom_range(1, 31));
				if (fl[4] && $urandom_range(0, 3) != 0) fl[4] = 1'b0;
				if (fl == 5'd0) fl = 5'd1;
				put_style(fl, $urandom_range(0, 31), $urandom, $urandom, $urandom,
					$urandom, $urandom, fw, sw);
			end
		end
		if ($urandom_range(0, 7) != 0) put_bits(32'd0, 6);
		send_shape(8'($urandom), {4'(fw), 4'(sw)});
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) send_request(CMD_DATA, 8'($urandom));
		end
	endtask

	initial begin
		logic [2:0] versions[9];
		rsp_t       missing;
		int         goal;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_idle = 26;
		sink_idle = 78;
		shapes_sent = 0;
		requests_counted = 0;
		settings_used = 0;
		versions = '{3'd3, 3'd4, 3'd0, 3'd2, 3'd7, 3'd1, 3'd5, 3'd3, 3'd6};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A request before any start is dropped.
		send_request(CMD_DATA, 8'hFF);
		// Zero-width move and styles with the new-styles flag ignored, extreme deltas,
		// both axis lines and a curve, then a byte after the end of the shape.
		put_style(5'b11111, 0, 0, 0, 0, 0, 0, 0, 0);
		put_line(15, 32'h0000_FFFF, 32'hFFFF_0000);
		put_axis(0, 1'b1, 32'h1);
		put_axis(0, 1'b0, 32'h2);
		put_curve(0, 32'h2, 32'h1, 32'h3, 32'h2);
		put_bits(32'd0, 6);
		send_shape(8'hFF, 8'h00);
		send_request(CMD_DATA, 8'h00);
		drain();
		// Full-width fills and a 3-bit line style, then the new-styles flag stops the shape with an error.
		write_version(3'd2);
		put_style(5'b11110, 0, 0, 0, 32'h7FFF, 0, 32'h7, 15, 3);
		send_shape(8'h00, 8'hF3);
		send_request(CMD_DATA, 8'hA5);
		drain();

		foreach (versions[p]) begin
			src_idle = (p < 3) ? 26 : (p < 6) ? 78 : 0;
			sink_idle = (p < 3) ? 78 : (p < 6) ? 26 : 0;
			write_version(versions[p]);
			goal = requests_counted + 104;
			while (requests_counted < goal) begin
				case ($urandom_range(0, 19))
					0: begin
						send_request(cmd_t'($urandom_range(0, 1)), 8'($urandom));
					end
					1, 2: begin
						send_request(CMD_START, 8'($urandom));
						send_request(CMD_DATA, 8'($urandom));
						repeat ($urandom_range(1, 6)) send_request(CMD_DATA, 8'($urandom));
					end
					default: random_shape();
				endcase
			end
			drain();
		end

		while (sb.expected_elements.size() != 0) begin
			missing = sb.expected_elements.pop_front();
			sb.report_mismatch($sformatf("element of kind %0d never arrived", missing.kind));
		end
		$display("Sent %0d requests: %0d generated shapes plus stray starts and data bytes,",
			requests_counted, shapes_sent);
		$display("under %0d shape_version writes; %0d path elements were checked.",
			settings_used, sb.checked);
		if (sb.errors == 0) begin
			$display("vector_shape_record_decoder_core regression: pass");
		end else begin
			$display("vector_shape_record_decoder_core regression: fail");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("vector_shape_record_decoder_core regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/vsrd_pkg.sv
hw/rtl/vsrd_bit_engine.sv
hw/rtl/vector_shape_record_decoder_core.sv
tb/tb.sv
